// ===== hdl/nprs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nprs_pkg
// Shared widths, constants, vector type and the arctangent table for the
// nonlinear phase rotation step pipeline.
// ----------------------------------------------------------------------------
package nprs_pkg;

  // Sample format (signed Q4.12) and step format (unsigned Q4.12)
  localparam int SAMPLE_BITS       = 16;
  localparam int STEP_BITS         = 16;
  localparam int FRAC              = 12;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_STAGES        = 32;

  localparam logic [STEP_BITS-1:0] STEP_TIME_RST = 16'd2048;

  // Power chain widths: m = |psi|^2, m12 = m >> 12, m2 = m12^2 >> 12, m3 = m2*m12 >> 12
  localparam int M_W   = 2 * SAMPLE_BITS;
  localparam int M12_W = M_W - FRAC;
  localparam int M2_W  = 2 * M12_W - FRAC;
  localparam int M3_W  = M2_W + M12_W - FRAC;
  localparam int P_W   = M3_W + STEP_BITS;

  // Radians (24 fraction bits) to binary angle (2^32 per turn)
  localparam int ANG_W    = 32;
  localparam int ANG_FRAC = 24;
  localparam int TPR_W    = 30;
  localparam logic [TPR_W-1:0] TURN_PER_RAD = 30'd683565276;
  localparam int PHI_W    = P_W - ANG_W;
  localparam int HIT_W    = ANG_W - (ANG_W - ANG_FRAC);

  // CORDIC datapath
  localparam int GAIN_W = 30;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032875;
  localparam int OUT_SHIFT = 30;
  localparam int XW = SAMPLE_BITS + 32;
  localparam int ZW = ANG_W + 2;
  localparam int RW = XW - OUT_SHIFT;

  localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [ZW-1:0] HALF_TURN    = 34'sd2147483648;

  // Register stages ahead of the CORDIC rotation
  localparam int FRONT_STAGES = 7;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } nprs_vec_t;

  function automatic int num_stages(input int n);
    num_stages = (n < MAX_STAGES) ? n : MAX_STAGES;
  endfunction

  function automatic int latency(input int n);
    latency = FRONT_STAGES + num_stages(n) + 1;
  endfunction

  function automatic logic [ANG_W-1:0] atan_turn(input logic [4:0] idx);
    logic [ANG_W-1:0] a;
    unique case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      5'd31: a = 32'h00000000;
    endcase
    atan_turn = a;
  endfunction

endpackage

// ===== hdl/nprs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nprs_front
// Seven-stage front end: |psi|^6 power chain, phase to binary angle,
// CORDIC gain prescale and quadrant fold.
// ----------------------------------------------------------------------------
module nprs_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic signed [nprs_pkg::SAMPLE_BITS-1:0] in_re,
  input  logic signed [nprs_pkg::SAMPLE_BITS-1:0] in_im,
  input  logic [nprs_pkg::STEP_BITS-1:0]          step_time,
  output logic                                   out_valid,
  output nprs_pkg::nprs_vec_t                    out_vec
);
  import nprs_pkg::*;

  logic [FRONT_STAGES-1:0] vld_r, vld_nxt;

  // stage 1: squares
  logic signed [SAMPLE_BITS-1:0] re1_r, im1_r;
  logic [M_W-1:0]                sqr1_r, sqi1_r, sqr1_nxt, sqi1_nxt;
  // stage 2: m12
  logic signed [SAMPLE_BITS-1:0] re2_r, im2_r;
  logic [M_W-1:0]                msum;
  logic [M12_W-1:0]              m12_2_r;
  // stage 3: m2
  logic signed [SAMPLE_BITS-1:0] re3_r, im3_r;
  logic [2*M12_W-1:0]            prod3;
  logic [M2_W-1:0]               m2_3_r;
  logic [M12_W-1:0]              m12_3_r;
  // stage 4: m3
  logic signed [SAMPLE_BITS-1:0] re4_r, im4_r;
  logic [M2_W+M12_W-1:0]         prod4;
  logic [M3_W-1:0]               m3_4_r;
  // stage 5: phase in radians
  logic signed [SAMPLE_BITS-1:0] re5_r, im5_r;
  logic [P_W-1:0]                p_5_r, p_5_nxt;
  // stage 6: angle partial products, gain prescale
  logic [ANG_W+TPR_W-1:0]        lop;
  logic [PHI_W+TPR_W-1:0]        hip;
  logic [ANG_W-1:0]              lot_6_r;
  logic [HIT_W-1:0]              hit_6_r;
  logic signed [XW-1:0]          x0_6_r, y0_6_r, x0_nxt, y0_nxt;
  // stage 7: fold
  logic [ANG_W-1:0]              ang;
  logic signed [ZW-1:0]          z_raw;
  nprs_vec_t                     vec_7_r, vec_nxt;

  assign vld_nxt  = {vld_r[FRONT_STAGES-2:0], in_valid};
  assign sqr1_nxt = M_W'(in_re) * M_W'(in_re);
  assign sqi1_nxt = M_W'(in_im) * M_W'(in_im);
  assign msum     = sqr1_r + sqi1_r;
  assign prod3    = m12_2_r * m12_2_r;
  assign prod4    = m2_3_r * m12_3_r;
  assign p_5_nxt  = m3_4_r * step_time;
  assign lop      = p_5_r[ANG_W-1:0] * TURN_PER_RAD;
  assign hip      = p_5_r[P_W-1:ANG_W] * TURN_PER_RAD;
  assign x0_nxt   = XW'(re5_r) * $signed({1'b0, GAIN_Q30});
  assign y0_nxt   = XW'(im5_r) * $signed({1'b0, GAIN_Q30});
  assign ang      = {hit_6_r, {(ANG_W-HIT_W){1'b0}}} + lot_6_r;
  assign z_raw    = ZW'($signed(ang));

  // Fold the angle into [-1/4, +1/4] turn, negating the vector when it is folded
  always_comb begin
    priority if (z_raw > QUARTER_TURN) begin
      vec_nxt.z = z_raw - HALF_TURN;
      vec_nxt.x = -x0_6_r;
      vec_nxt.y = -y0_6_r;
    end else if (z_raw < -QUARTER_TURN) begin
      vec_nxt.z = z_raw + HALF_TURN;
      vec_nxt.x = -x0_6_r;
      vec_nxt.y = -y0_6_r;
    end else begin
      vec_nxt.z = z_raw;
      vec_nxt.x = x0_6_r;
      vec_nxt.y = y0_6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    re1_r   <= in_re;
    im1_r   <= in_im;
    sqr1_r  <= sqr1_nxt;
    sqi1_r  <= sqi1_nxt;
    re2_r   <= re1_r;
    im2_r   <= im1_r;
    m12_2_r <= msum[M_W-1:FRAC];
    re3_r   <= re2_r;
    im3_r   <= im2_r;
    m2_3_r  <= prod3[2*M12_W-1:FRAC];
    m12_3_r <= m12_2_r;
    re4_r   <= re3_r;
    im4_r   <= im3_r;
    m3_4_r  <= prod4[M2_W+M12_W-1:FRAC];
    re5_r   <= re4_r;
    im5_r   <= im4_r;
    p_5_r   <= p_5_nxt;
    lot_6_r <= lop[ANG_W+ANG_FRAC-1:ANG_FRAC];
    hit_6_r <= hip[HIT_W-1:0];
    x0_6_r  <= x0_nxt;
    y0_6_r  <= y0_nxt;
    vec_7_r <= vec_nxt;
  end

  assign out_valid = vld_r[FRONT_STAGES-1];
  assign out_vec   = vec_7_r;

endmodule

// ===== hdl/nprs_cordic_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nprs_cordic_stage
// One registered CORDIC rotation micro-step with a fixed shift.
// ----------------------------------------------------------------------------
module nprs_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  nprs_pkg::nprs_vec_t in_vec,
  output logic                out_valid,
  output nprs_pkg::nprs_vec_t out_vec
);
  import nprs_pkg::*;

  localparam logic [ANG_W-1:0] ATAN = atan_turn(5'(IDX));

  logic                 vld_r;
  nprs_vec_t            vec_r, vec_nxt;
  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] da;

  assign dx = in_vec.y >>> IDX;
  assign dy = in_vec.x >>> IDX;
  assign da = $signed(ZW'(ATAN));

  // Rotate toward zero residual angle
  always_comb begin
    if (in_vec.z >= 0) begin
      vec_nxt.x = in_vec.x - dx;
      vec_nxt.y = in_vec.y + dy;
      vec_nxt.z = in_vec.z - da;
    end else begin
      vec_nxt.x = in_vec.x + dx;
      vec_nxt.y = in_vec.y - dy;
      vec_nxt.z = in_vec.z + da;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
  end

  assign out_valid = vld_r;
  assign out_vec   = vec_r;

endmodule

// ===== hdl/nprs_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nprs_out
// Round the rotated vector to Q4.12 and saturate, with a clip flag.
// ----------------------------------------------------------------------------
module nprs_out (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  nprs_pkg::nprs_vec_t                    in_vec,
  output logic                                   out_valid,
  output logic signed [nprs_pkg::SAMPLE_BITS-1:0] out_re,
  output logic signed [nprs_pkg::SAMPLE_BITS-1:0] out_im,
  output logic                                   out_sat
);
  import nprs_pkg::*;

  localparam logic signed [XW-1:0] HALF_LSB = XW'(1) <<< (OUT_SHIFT - 1);
  localparam logic signed [RW-1:0] MAX_R    = RW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] MIN_R    = -MAX_R - RW'(1);

  logic                          vld_r;
  logic signed [XW-1:0]          xb, yb;
  logic signed [RW-1:0]          xr, yr;
  logic signed [SAMPLE_BITS-1:0] re_r, im_r, re_nxt, im_nxt;
  logic                          sat_r, sat_nxt, clip_x, clip_y;

  assign xb = in_vec.x + HALF_LSB;
  assign yb = in_vec.y + HALF_LSB;
  assign xr = xb[XW-1:OUT_SHIFT];
  assign yr = yb[XW-1:OUT_SHIFT];

  always_comb begin
    clip_x = 1'b1;
    priority if (xr > MAX_R) begin
      re_nxt = MAX_R[SAMPLE_BITS-1:0];
    end else if (xr < MIN_R) begin
      re_nxt = MIN_R[SAMPLE_BITS-1:0];
    end else begin
      re_nxt = xr[SAMPLE_BITS-1:0];
      clip_x = 1'b0;
    end
  end

  always_comb begin
    clip_y = 1'b1;
    priority if (yr > MAX_R) begin
      im_nxt = MAX_R[SAMPLE_BITS-1:0];
    end else if (yr < MIN_R) begin
      im_nxt = MIN_R[SAMPLE_BITS-1:0];
    end else begin
      im_nxt = yr[SAMPLE_BITS-1:0];
      clip_y = 1'b0;
    end
  end

  // Hold the flag low between results
  assign sat_nxt = in_valid & (clip_x | clip_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sat_r <= 1'b0;
    end else begin
      vld_r <= in_valid;
      sat_r <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    re_r <= re_nxt;
    im_r <= im_nxt;
  end

  assign out_valid = vld_r;
  assign out_re    = re_r;
  assign out_im    = im_r;
  assign out_sat   = sat_r;

endmodule

// ===== hdl/nonlinear_phase_rotation_step_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonlinear_phase_rotation_step_top
// Rotates each complex Q4.12 sample by |psi|^6 * step_time (nonlinear half
// step of a split-step scheme), CORDIC rotation, saturated output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_sample_re/in_sample_im and raise start; the
//   transaction is taken on any rising edge with start high and busy low.
//   busy is registered: high during reset, it clears at the first clock edge
//   with rst_n high, then stays low, so a new sample can enter every cycle.
//   Result channel: out_valid is high for exactly one cycle with
//   out_rotated_re, out_rotated_im and out_saturated. There is no
//   backpressure; the receiver must take the result in that cycle.
//   Pipeline: each sample passes the 7 front stages (|psi|^6 power chain and
//   angle conversion), one register per CORDIC micro-step and one rounding
//   stage, which raises out_valid with its result.
//   Throughput: one sample per clock, set by the fully pipelined datapath.
//   Config channel: cfg_step_time is written when cfg_valid and cfg_ready
//   are both high; change it only while no samples are in flight.
//   Reset (synchronous, rst_n low): flushes all in-flight samples, loads
//   step_time with 0.5 (2048) and holds busy high.
// ----------------------------------------------------------------------------
module nonlinear_phase_rotation_step_top #(
  parameter int CORDIC_STAGES = nprs_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [nprs_pkg::SAMPLE_BITS-1:0] in_sample_re,
  input  logic signed [nprs_pkg::SAMPLE_BITS-1:0] in_sample_im,
  // result channel
  output logic                                   out_valid,
  output logic signed [nprs_pkg::SAMPLE_BITS-1:0] out_rotated_re,
  output logic signed [nprs_pkg::SAMPLE_BITS-1:0] out_rotated_im,
  output logic                                   out_saturated,
  // configuration channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [nprs_pkg::STEP_BITS-1:0]          cfg_step_time
);
  import nprs_pkg::*;

  // Stages beyond the arctangent table are not built
  localparam int NSTG = num_stages(CORDIC_STAGES);

  logic                 busy_r;
  logic [STEP_BITS-1:0] step_time_r;
  logic                 accept;

  logic                 cvld [0:NSTG];
  nprs_vec_t            cvec [0:NSTG];

  assign accept    = start & ~busy_r;
  assign busy      = busy_r;
  assign cfg_ready = ~busy_r;

  // busy: high through reset, low once rst_n is high; step_time is loaded on a cfg handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      step_time_r <= STEP_TIME_RST;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        step_time_r <= cfg_step_time;
      end
    end
  end

  // Power chain, angle conversion, prescale and quadrant fold
  nprs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_re     (in_sample_re),
    .in_im     (in_sample_im),
    .step_time (step_time_r),
    .out_valid (cvld[0]),
    .out_vec   (cvec[0])
  );

  // One register stage per CORDIC micro-step
  for (genvar k = 0; k < NSTG; k++) begin : g_cordic
    nprs_cordic_stage #(
      .IDX (k)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cvld[k]),
      .in_vec    (cvec[k]),
      .out_valid (cvld[k+1]),
      .out_vec   (cvec[k+1])
    );
  end

  // Round, saturate and strobe the result
  nprs_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cvld[NSTG]),
    .in_vec    (cvec[NSTG]),
    .out_valid (out_valid),
    .out_re    (out_rotated_re),
    .out_im    (out_rotated_im),
    .out_sat   (out_saturated)
  );

endmodule

// ===== hdl/nprs_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nprs_chk
// Port-level checks on latency, result strobes and the zero-sample case.
// ----------------------------------------------------------------------------
module nprs_chk #(
  parameter int CORDIC_STAGES = nprs_pkg::CORDIC_STAGES_DEF
) (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   start,
  input logic                                   busy,
  input logic signed [nprs_pkg::SAMPLE_BITS-1:0] in_sample_re,
  input logic signed [nprs_pkg::SAMPLE_BITS-1:0] in_sample_im,
  input logic                                   out_valid,
  input logic signed [nprs_pkg::SAMPLE_BITS-1:0] out_rotated_re,
  input logic signed [nprs_pkg::SAMPLE_BITS-1:0] out_rotated_im,
  input logic                                   out_saturated
);
  import nprs_pkg::*;

  localparam int LAT = latency(CORDIC_STAGES);

  // Every accepted transaction gives a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("no result after accepted transaction");

  // No result without a transaction accepted the fixed latency earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching transaction");

  // A zero sample has zero phase and comes back as zero
  a_zero_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_sample_re == 0 && in_sample_im == 0) |-> ##LAT
      (out_rotated_re == 0 && out_rotated_im == 0 && !out_saturated))
    else $error("zero sample not returned as zero");

  // Clip flag only accompanies a result
  a_sat_qualified: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !out_saturated)
    else $error("saturation flag without result");

endmodule

bind nonlinear_phase_rotation_step_top nprs_chk #(
  .CORDIC_STAGES (CORDIC_STAGES)
) u_nprs_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_sample_re   (in_sample_re),
  .in_sample_im   (in_sample_im),
  .out_valid      (out_valid),
  .out_rotated_re (out_rotated_re),
  .out_rotated_im (out_rotated_im),
  .out_saturated  (out_saturated)
);
